// ===== hw/rtl/led_block_cipher_encrypt_assert.svh =====
// assertion macros used by the cipher controller rtl
`ifndef LED_BLOCK_CIPHER_ENCRYPT_ASSERT_SVH
`define LED_BLOCK_CIPHER_ENCRYPT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LBCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LBCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lbce_pkg.sv =====
`timescale 1ns / 1ps

package lbce_pkg;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_BITS        = 2'd0;
  localparam cfg_idx_t CFG_KEY_FIRST_HALF  = 2'd1;
  localparam cfg_idx_t CFG_KEY_SECOND_HALF = 2'd2;

  localparam int          CELLS          = 16;
  localparam logic [7:0]  KEY_BITS_MIN   = 8'd64;
  localparam logic [5:0]  SHORT_LAST_RND = 6'd31;
  localparam logic [5:0]  LONG_LAST_RND  = 6'd47;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       round_en;
    logic       key_add;
    logic       push;
    logic [5:0] rnd;
  } lbce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic long_key;
  } lbce_sts_t;

  localparam logic [3:0] MIX [4][4] = '{
    '{4'h4, 4'h1, 4'h2, 4'h2},
    '{4'h8, 4'h6, 4'h5, 4'h6},
    '{4'hB, 4'hE, 4'hA, 4'h9},
    '{4'h2, 4'h2, 4'hF, 4'hB}
  };

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // multiply in gf(2^4), x^4 + x + 1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] x;
    logic [3:0] acc;
    x   = a;
    acc = 4'h0;
    for (int n = 0; n < 4; n++) begin
      if (b[n]) acc = acc ^ x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  function automatic logic [5:0] round_const(input logic [5:0] r);
    logic [5:0] c;
    case (r)
      6'd0:  c = 6'h01;  6'd1:  c = 6'h03;  6'd2:  c = 6'h07;  6'd3:  c = 6'h0F;
      6'd4:  c = 6'h1F;  6'd5:  c = 6'h3E;  6'd6:  c = 6'h3D;  6'd7:  c = 6'h3B;
      6'd8:  c = 6'h37;  6'd9:  c = 6'h2F;  6'd10: c = 6'h1E;  6'd11: c = 6'h3C;
      6'd12: c = 6'h39;  6'd13: c = 6'h33;  6'd14: c = 6'h27;  6'd15: c = 6'h0E;
      6'd16: c = 6'h1D;  6'd17: c = 6'h3A;  6'd18: c = 6'h35;  6'd19: c = 6'h2B;
      6'd20: c = 6'h16;  6'd21: c = 6'h2C;  6'd22: c = 6'h18;  6'd23: c = 6'h30;
      6'd24: c = 6'h21;  6'd25: c = 6'h02;  6'd26: c = 6'h05;  6'd27: c = 6'h0B;
      6'd28: c = 6'h17;  6'd29: c = 6'h2E;  6'd30: c = 6'h1C;  6'd31: c = 6'h38;
      6'd32: c = 6'h31;  6'd33: c = 6'h23;  6'd34: c = 6'h06;  6'd35: c = 6'h0D;
      6'd36: c = 6'h1B;  6'd37: c = 6'h36;  6'd38: c = 6'h2D;  6'd39: c = 6'h1A;
      6'd40: c = 6'h34;  6'd41: c = 6'h29;  6'd42: c = 6'h12;  6'd43: c = 6'h24;
      6'd44: c = 6'h08;  6'd45: c = 6'h11;  6'd46: c = 6'h22;  6'd47: c = 6'h04;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/lbce_datapath.sv =====
`timescale 1ns / 1ps

module lbce_datapath import lbce_pkg::*; #(
  parameter int MAX_KEY_NIBBLES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] in_plaintext,
  output logic [63:0] out_ciphertext,
  input  lbce_cmd_t cmd,
  output lbce_sts_t sts
);

  localparam int NW = $clog2(MAX_KEY_NIBBLES) + 1;
  localparam int KSW = 4 * (MAX_KEY_NIBBLES - 16);
  localparam logic [7:0] KEY_BITS_MAX = 8'(4 * MAX_KEY_NIBBLES);

  logic [7:0]  key_bits_r;
  logic [63:0] key_first_r;
  logic [3:0]  key_nib [MAX_KEY_NIBBLES];

  logic [63:0] state_r;
  logic [63:0] ct_r;
  logic [3:0]  krot_r   [MAX_KEY_NIBBLES];
  logic [3:0]  krot_nxt [MAX_KEY_NIBBLES];
  logic [3:0]  hd [4];

  logic [7:0]    kb_clip;
  logic [7:0]    kb_eff;
  logic [NW-1:0] nk;
  logic [NW-1:0] wrap_d;
  logic [5:0]    rc;
  logic [3:0]    c [CELLS];
  logic [3:0]    s [CELLS];
  logic [3:0]    t [CELLS];
  logic [3:0]    m [CELLS];
  logic [63:0]   round_out;
  logic [63:0]   step_key;
  logic [63:0]   first_key;
  logic [63:0]   step_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bits_r  <= KEY_BITS_MIN;
      key_first_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_BITS) key_bits_r <= cfg_data[7:0];
      if (cfg_index == CFG_KEY_FIRST_HALF) key_first_r <= cfg_data;
    end
  end

  for (genvar n = 0; n < 16; n++) begin : g_first
    assign key_nib[n] = key_first_r[63-4*n -: 4];
  end

  if (MAX_KEY_NIBBLES > 16) begin : g_second
    logic [KSW-1:0] key_second_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_second_r <= '0;
      end else if (cfg_we && (cfg_index == CFG_KEY_SECOND_HALF)) begin
        key_second_r <= cfg_data[63 -: KSW];
      end
    end
    for (genvar n = 0; n < MAX_KEY_NIBBLES - 16; n++) begin : g_nib
      assign key_nib[16+n] = key_second_r[KSW-1-4*n -: 4];
    end
  end

  // clamp the key size, round down to whole nibbles
  always_comb begin
    if (key_bits_r < KEY_BITS_MIN) kb_clip = KEY_BITS_MIN;
    else if (key_bits_r > KEY_BITS_MAX) kb_clip = KEY_BITS_MAX;
    else kb_clip = key_bits_r;
    kb_eff = {kb_clip[7:2], 2'b00};
    nk = NW'(kb_eff[7:2]);
  end

  assign sts.long_key = (kb_eff > KEY_BITS_MIN);

  // key ring rotates four nibbles per round, wrapping at nk
  always_comb begin
    for (int h = 0; h < 4; h++) hd[h] = krot_r[h];
    for (int j = 0; j < MAX_KEY_NIBBLES; j++) begin
      wrap_d = NW'(j + 4) - nk;
      if (NW'(j + 4) >= nk) krot_nxt[j] = hd[wrap_d[1:0]];
      else krot_nxt[j] = krot_r[(j + 4) % MAX_KEY_NIBBLES];
    end
  end

  // one round: constants, s-box, row shift, column mix, then the step key when key_add is set
  always_comb begin
    rc = round_const(cmd.rnd);
    for (int i = 0; i < CELLS; i++) c[i] = state_r[63-4*i -: 4];
    c[0]  = c[0]  ^ kb_eff[7:4];
    c[4]  = c[4]  ^ (4'h1 ^ kb_eff[7:4]);
    c[8]  = c[8]  ^ (4'h2 ^ kb_eff[3:0]);
    c[12] = c[12] ^ (4'h3 ^ kb_eff[3:0]);
    c[1]  = c[1]  ^ {1'b0, rc[5:3]};
    c[9]  = c[9]  ^ {1'b0, rc[5:3]};
    c[5]  = c[5]  ^ {1'b0, rc[2:0]};
    c[13] = c[13] ^ {1'b0, rc[2:0]};
    for (int i = 0; i < CELLS; i++) s[i] = sbox(c[i]);
    for (int r = 0; r < 4; r++)
      for (int col = 0; col < 4; col++)
        t[4*r+col] = s[4*r + ((col + r) % 4)];
    for (int r = 0; r < 4; r++)
      for (int col = 0; col < 4; col++) begin
        m[4*r+col] = 4'h0;
        for (int k = 0; k < 4; k++)
          m[4*r+col] = m[4*r+col] ^ gf_mul(MIX[r][k], t[4*k+col]);
      end
    for (int i = 0; i < CELLS; i++) begin
      round_out[63-4*i -: 4] = m[i];
      step_key[63-4*i -: 4]  = krot_nxt[i];
      first_key[63-4*i -: 4] = key_nib[i];
    end
    step_out = round_out ^ (cmd.key_add ? step_key : 64'h0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state_r <= in_plaintext ^ first_key;
      krot_r  <= key_nib;
    end else if (cmd.round_en) begin
      state_r <= step_out;
      krot_r  <= krot_nxt;
    end
    if (cmd.push) ct_r <= step_out;
  end

  assign out_ciphertext = ct_r;

endmodule

// ===== hw/rtl/lbce_ctrl.sv =====
`timescale 1ns / 1ps
`include "led_block_cipher_encrypt_assert.svh"

module lbce_ctrl import lbce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output lbce_cmd_t cmd,
  input  lbce_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] last_rnd;
  logic       out_blocked;
  logic       advance;
  logic       is_last;

  assign last_rnd    = sts.long_key ? LONG_LAST_RND : SHORT_LAST_RND;
  assign out_blocked = out_valid_r && out_stall;
  assign is_last     = (rnd_r == last_rnd);
  // the final round waits while the previous result is still held
  assign advance     = (state_r == S_RUN) && !(is_last && out_blocked);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load     = in_valid && (state_r == S_IDLE);
    cmd.round_en = advance;
    cmd.push     = advance && is_last;
    cmd.key_add  = (rnd_r[1:0] == 2'b11);
    cmd.rnd      = rnd_r;
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_RUN;
          rnd_nxt   = '0;
        end
      end
      S_RUN: begin
        if (advance) begin
          if (is_last) state_nxt = S_IDLE;
          else rnd_nxt = rnd_r + 6'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.push) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LBCE_ASSERT_IMP(a_busy_stalls, clk, rst_n, state_r == S_RUN, in_stall, "beat taken while busy")
  `LBCE_ASSERT_NXT(a_load_starts, clk, rst_n, cmd.load, (state_r == S_RUN) && (rnd_r == 6'd0), "load did not start rounds")
  `LBCE_ASSERT_IMP(a_rnd_range, clk, rst_n, state_r == S_RUN, rnd_r <= last_rnd, "round counter past last round")
  `LBCE_ASSERT_IMP(a_push_free, clk, rst_n, cmd.push, !out_blocked, "result pushed over a held beat")

endmodule

// ===== hw/rtl/led_block_cipher_encrypt.sv =====
`timescale 1ns / 1ps
// led 64-bit block cipher, encryption only. one plaintext beat in, one
// ciphertext beat out. the key size (64..128 bits, clamped and rounded down
// to whole nibbles) and the key live in configuration registers written over
// the cfg port; the user must write them only while the core is idle, which
// the block does not enforce. a block takes a load step (key whitening) and
// then its rounds through the shared round unit: 32 rounds for 64-bit keys
// and 48 for longer keys. the next plaintext is taken as soon as the round
// unit is free, while the finished ciphertext waits in the output register.

module led_block_cipher_encrypt import lbce_pkg::*; #(
  parameter int MAX_KEY_NIBBLES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [63:0] cfg_data,
  // plaintext beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_plaintext,
  // ciphertext beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_ciphertext
);

  // round sequencing commands and key-size status
  lbce_cmd_t cmd;
  lbce_sts_t sts;

  // controller: idle/run sequencing, round counter, output valid
  lbce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: key registers, rotating key ring, cipher state, round unit
  lbce_datapath #(
    .MAX_KEY_NIBBLES (MAX_KEY_NIBBLES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_plaintext   (in_plaintext),
    .out_ciphertext (out_ciphertext),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== sim/tb_led_block_cipher_encrypt.sv =====
`timescale 1ns / 1ps

module tb_led_block_cipher_encrypt;
  import lbce_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 60;
  localparam int DIR_ROWS       = 23;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KA   = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] KB   = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] ALT  = 64'hAAAA_AAAA_AAAA_AAAA;

  // cipher tables for the predictor
  localparam logic [3:0] SUB_TBL [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] MIX_COEF [4][4] = '{
    '{4'h4, 4'h1, 4'h2, 4'h2},
    '{4'h8, 4'h6, 4'h5, 4'h6},
    '{4'hB, 4'hE, 4'hA, 4'h9},
    '{4'h2, 4'h2, 4'hF, 4'hB}
  };
  localparam logic [5:0] RC_TBL [48] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
    6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
    6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
    6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38,
    6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  // directed rows: key size word, key halves, plaintext
  typedef struct packed {
    logic [63:0] kb_word;
    logic [63:0] khi;
    logic [63:0] klo;
    logic [63:0] plain;
  } dir_row_t;

  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    // 64-bit keys, plaintext extremes and single bits
    '{64'd64, 64'h0, 64'h0, 64'h0},
    '{64'd64, 64'h0, 64'h0, ONES},
    '{64'd64, 64'h0, 64'h0, 64'h8000_0000_0000_0000},
    '{64'd64, 64'h0, 64'h0, 64'h0000_0000_0000_0001},
    '{64'd64, ONES, 64'h0, 64'h0},
    '{64'd64, ONES, 64'h0, ONES},
    '{64'd64, KA, 64'h0, KA},
    // full 128-bit key, halves alternate per step
    '{64'd128, 64'h0, 64'h0, 64'h0},
    '{64'd128, ONES, ONES, ONES},
    '{64'd128, KA, KB, KA},
    '{64'd128, 64'h0, ONES, 64'h5555_5555_5555_5555},
    // odd nibble counts, schedule wraps in the middle of a block
    '{64'd68, KA, 64'hF000_0000_0000_0000, ALT},
    '{64'd124, KB, KA, 64'h0F0F_0F0F_0F0F_0F0F},
    // key size below range clamps to 64
    '{64'd0, KA, ONES, ALT},
    '{64'd63, KB, ONES, ALT},
    // key size above range clamps to 128
    '{64'd255, KA, KB, 64'h0},
    '{64'd129, KB, KA, ONES},
    // key size not a multiple of four rounds down
    '{64'd66, KA, KB, 64'h1234_5678_9ABC_DEF0},
    '{64'd67, KB, KA, 64'h1234_5678_9ABC_DEF0},
    '{64'd101, KA, KB, 64'hDEAD_BEEF_0BAD_F00D},
    '{64'd127, KA, KB, 64'hDEAD_BEEF_0BAD_F00D},
    // only the low byte of the key size word counts
    '{64'hFFFF_FFFF_FFFF_FF50, KB, KA, 64'h0},
    '{64'd64, 64'h0, 64'h0, 64'hF0F0_F0F0_F0F0_F0F0}
  };

  typedef struct {
    logic [63:0] plain;
    logic [63:0] cipher;
  } block_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  cfg_idx_t    cfg_index      = CFG_KEY_BITS;
  logic [63:0] cfg_data       = 64'h0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [63:0] in_plaintext   = 64'h0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [63:0] out_ciphertext;

  // key registers as the block should hold them
  logic [7:0]  kbits_q = 8'd64;
  logic [63:0] khi_q   = 64'h0;
  logic [63:0] klo_q   = 64'h0;

  block_t      pending_ct [$];
  block_t      head;
  int          err_count    = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  bit          calm         = 1'b0;
  bit          idle_on      = 1'b1;

  always #2 clk = ~clk;

  led_block_cipher_encrypt DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_plaintext   (in_plaintext),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ciphertext (out_ciphertext)
  );

  // multiply in gf(2^4) mod x^4+x+1, msb first
  function automatic logic [3:0] gf4_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] p;
    p = 4'h0;
    for (int n = 3; n >= 0; n--) begin
      p = {p[2:0], 1'b0} ^ (p[3] ? 4'h3 : 4'h0);
      if (b[n]) p ^= a;
    end
    return p;
  endfunction

  function automatic logic [63:0] led_encrypt(input logic [63:0] plain,
                                              input logic [7:0]  kbits,
                                              input logic [63:0] khi,
                                              input logic [63:0] klo);
    logic [127:0] key;
    logic [3:0]   st [16];
    logic [3:0]   sh [16];
    logic [3:0]   acc;
    logic [7:0]   kb;
    logic [5:0]   rc;
    logic [63:0]  ct;
    int           nk;
    int           steps;
    key = {khi, klo};
    kb  = kbits;
    if (kb < 8'd64) kb = 8'd64;
    if (kb > 8'd128) kb = 8'd128;
    kb[1:0] = 2'b00;
    nk    = int'(kb) / 4;
    steps = (kb > 8'd64) ? 12 : 8;
    for (int i = 0; i < 16; i++) st[i] = plain[63 - 4 * i -: 4];
    for (int s = 0; s <= steps; s++) begin
      // key nibbles wrap around the key length
      for (int i = 0; i < 16; i++) st[i] ^= key[127 - 4 * ((16 * s + i) % nk) -: 4];
      if (s < steps) begin
        for (int j = 0; j < 4; j++) begin
          rc = RC_TBL[4 * s + j];
          st[0]  ^= kb[7:4];
          st[4]  ^= 4'h1 ^ kb[7:4];
          st[8]  ^= 4'h2 ^ kb[3:0];
          st[12] ^= 4'h3 ^ kb[3:0];
          st[1]  ^= {1'b0, rc[5:3]};
          st[9]  ^= {1'b0, rc[5:3]};
          st[5]  ^= {1'b0, rc[2:0]};
          st[13] ^= {1'b0, rc[2:0]};
          for (int i = 0; i < 16; i++) st[i] = SUB_TBL[st[i]];
          for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
              sh[4 * row + col] = st[4 * row + ((col + row) % 4)];
          for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++) begin
              acc = 4'h0;
              for (int k = 0; k < 4; k++) acc ^= gf4_mul(MIX_COEF[row][k], sh[4 * k + col]);
              st[4 * row + col] = acc;
            end
        end
      end
    end
    for (int i = 0; i < 16; i++) ct[63 - 4 * i -: 4] = st[i];
    return ct;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // one plaintext beat, optionally after a gap with valid low
  task automatic send_block(input logic [63:0] plain, input int gap);
    block_t b;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_plaintext <= plain;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    b.plain  = plain;
    b.cipher = led_encrypt(plain, kbits_q, khi_q, klo_q);
    pending_ct.push_back(b);
    @(negedge clk);
  endtask

  // hold off the sender until every ciphertext is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_ct.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_KEY_BITS:        kbits_q = val[7:0];
      CFG_KEY_FIRST_HALF:  khi_q   = val;
      CFG_KEY_SECOND_HALF: klo_q   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // key changes only while the core is idle
  task automatic setup_key(input logic [63:0] kb_word, input logic [63:0] khi,
                           input logic [63:0] klo);
    wait_idle();
    if (kb_word[7:0] != kbits_q) write_reg(CFG_KEY_BITS, kb_word);
    if (khi != khi_q) write_reg(CFG_KEY_FIRST_HALF, khi);
    if (klo != klo_q) write_reg(CFG_KEY_SECOND_HALF, klo);
    cfg_we <= 1'b0;
  endtask

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (!rst_n || calm || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ciphertext checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ct.size() == 0) begin
        report_mismatch($sformatf("unexpected ciphertext %h", out_ciphertext));
      end else begin
        head = pending_ct.pop_front();
        if (out_ciphertext !== head.cipher)
          report_mismatch($sformatf("plaintext %h: ciphertext %h, want %h",
                                    head.plain, out_ciphertext, head.cipher));
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] kb_word;
    logic [63:0] khi;
    logic [63:0] klo;
    logic [63:0] plain;
    int          gap;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows, key rewritten whenever a row asks for another one
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TBL[r].kb_word[7:0] != kbits_q || DIR_TBL[r].khi != khi_q ||
          DIR_TBL[r].klo != klo_q)
        setup_key(DIR_TBL[r].kb_word, DIR_TBL[r].khi, DIR_TBL[r].klo);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      send_block(DIR_TBL[r].plain, gap);
    end

    // random phases, each under its own key; the last one runs flat out
    for (int p = 0; p < PHASES; p++) begin
      kb_word = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) kb_word[63:8] = '0;
      case (p)
        0: kb_word[7:0] = 8'd64;
        1: kb_word[7:0] = 8'd128;
        default: begin
          case ($urandom_range(0, 4))
            0: kb_word[7:0] = 8'd64;
            1: kb_word[7:0] = 8'd128;
            2: kb_word[7:0] = 8'(4 * $urandom_range(17, 31));
            3: kb_word[7:0] = 8'($urandom_range(0, 63));
            default: kb_word[7:0] = 8'($urandom_range(0, 255));
          endcase
        end
      endcase
      khi = {$urandom, $urandom};
      klo = {$urandom, $urandom};
      setup_key(kb_word, khi, klo);
      calm    = (p == PHASES - 1);
      idle_on = (p != 3);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // now and then let the core run empty before the next beat
        if (!calm && $urandom_range(0, 49) == 0) wait_idle();
        case ($urandom_range(0, 15))
          0:       plain = 64'h0;
          1:       plain = ONES;
          2:       plain = 64'h1 << $urandom_range(0, 63);
          default: plain = {$urandom, $urandom};
        endcase
        gap = (!calm && idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        send_block(plain, gap);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== led_block_cipher_encrypt.f =====
+incdir+hw/rtl
hw/rtl/lbce_pkg.sv
hw/rtl/lbce_datapath.sv
hw/rtl/lbce_ctrl.sv
hw/rtl/led_block_cipher_encrypt.sv
sim/tb_led_block_cipher_encrypt.sv
